>>> src/cpac_pkg.sv
// Shared types, field widths and colour tables for the channel power averager.
`default_nettype none

package cpac_pkg;

    // Field widths of the stream beats
    localparam int CHAN_W         = 7;
    localparam int LEVEL_W        = 7;
    localparam int SHADE_W        = 8;
    localparam int COLOR_W        = 16;
    localparam int SWEEP_W        = 32;
    localparam int SUM_W          = 9;
    localparam int S_TDATA_W      = 8;
    localparam int M_FIELDS_W     = CHAN_W + LEVEL_W + SHADE_W + COLOR_W + SWEEP_W;
    localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W        = M_TDATA_W - M_FIELDS_W;
    localparam int LEVEL_ENTRIES  = 2 ** LEVEL_W;
    localparam int SHADE_ENTRIES  = 2 ** SHADE_W;

    // Default number of radio channels
    localparam int CHANNEL_COUNT_DEF = 80;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_EMIT
    } cpac_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic read;
        logic calc;
        logic emit;
    } cpac_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic out_busy;
    } cpac_status_t;

    // Magma ramp control points, one array per colour component
    localparam int RAMP_R [5] = '{0, 80, 182, 251, 252};
    localparam int RAMP_G [5] = '{0, 18, 54, 136, 253};
    localparam int RAMP_B [5] = '{4, 123, 121, 97, 191};

    typedef logic [SHADE_W-1:0] shade_lut_t [LEVEL_ENTRIES];
    typedef logic [COLOR_W-1:0] magma_lut_t [SHADE_ENTRIES];

    // Level to shade byte with the 3.06x boost and saturation; built at elaboration
    function automatic shade_lut_t build_shade_lut();
        shade_lut_t lut;
        int         s;
        for (int i = 0; i < LEVEL_ENTRIES; i++) begin
            s = (i * 765) / 250;
            if (s > 255) begin
                s = 255;
            end
            lut[i] = SHADE_W'(s);
        end
        return lut;
    endfunction

    // Shade byte to byte-swapped RGB565 magma colour; built at elaboration
    function automatic magma_lut_t build_magma_lut();
        magma_lut_t       lut;
        int               seg;
        int               rem;
        int               r;
        int               g;
        int               b;
        logic [COLOR_W-1:0] p;
        for (int i = 0; i < SHADE_ENTRIES; i++) begin
            seg = (4 * i) / 255;
            if (seg > 3) begin
                seg = 3;
            end
            rem = 4 * i - 255 * seg;
            r = (255 * RAMP_R[seg] + (RAMP_R[seg + 1] - RAMP_R[seg]) * rem) / 255;
            g = (255 * RAMP_G[seg] + (RAMP_G[seg + 1] - RAMP_G[seg]) * rem) / 255;
            b = (255 * RAMP_B[seg] + (RAMP_B[seg + 1] - RAMP_B[seg]) * rem) / 255;
            p = {r[7:3], g[7:2], b[7:3]};
            lut[i] = {p[7:0], p[15:8]};
        end
        return lut;
    endfunction

    localparam shade_lut_t SHADE_LUT = build_shade_lut();
    localparam magma_lut_t MAGMA_LUT = build_magma_lut();

endpackage

`default_nettype wire

>>> src/channel_power_average_colormap_unit.sv
// Top level of the channel power averager with magma colour ramp.
//
//  Channel | Direction | Handshake          | Content
//  s_      | in        | s_tvalid/s_tready  | tdata: channel, power_hit
//  m_      | out       | m_tvalid/m_tready  | tdata: chan_out .. sweep_total; tlast: sweep_end
//
// Each sample passes through the steps accept, level store read, average and shade,
// colour lookup into the output register; the registered read of the level RAM
// is the second of them.
// The output register lets a new sample be accepted while a result beat waits.
// A stalled result beat holds the sequencer in its last step until m_tready.
// Reset clears the level valid bits, the sweep count and the output valid flag.
`default_nettype none

module channel_power_average_colormap_unit #(
    parameter int CHANNEL_COUNT = cpac_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // [6:0] channel, [7] power_hit
    input  wire logic [cpac_pkg::S_TDATA_W-1:0] s_tdata,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [6:0] chan_out, [13:7] avg_level, [21:14] shade, [37:22] pixel_color,
    // [69:38] sweep_total, [71:70] zero
    output      logic [cpac_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                           m_tlast
);

    cpac_pkg::cpac_cmd_t    cmd;
    cpac_pkg::cpac_status_t status;

    // Sequencer
    cpac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    cpac_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // One sample in flight: no beat is taken in the cycle after an accepted one.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // The averaged level never leaves its range.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:7] <= 7'd125))
        else $error("averaged level above 125");

    // A sweep end is only reported for the last channel.
    a_sweep_end_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[6:0] == cpac_pkg::CHAN_W'(CHANNEL_COUNT - 1)))
        else $error("sweep end on a channel other than the last");

endmodule

`default_nettype wire

>>> src/cpac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cpac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/cpac_ctrl.sv
// Sequencer for the channel power averager: one sample at a time.
`default_nettype none

module cpac_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic                  m_tready,
    input  wire cpac_pkg::cpac_status_t status,
    output      cpac_pkg::cpac_cmd_t   cmd
);

    cpac_pkg::cpac_state_t state_reg;
    cpac_pkg::cpac_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpac_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            cpac_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = cpac_pkg::ST_READ;
                end
            end
            cpac_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = cpac_pkg::ST_CALC;
            end
            cpac_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = cpac_pkg::ST_EMIT;
            end
            cpac_pkg::ST_EMIT: begin
                // Wait until the output register is free or drains this cycle
                if (!status.out_busy || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = cpac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/cpac_datapath.sv
// Datapath: level store, averaging, shade and colour lookup, sweep count, output register.
`default_nettype none

module cpac_datapath #(
    parameter int CHANNEL_COUNT = cpac_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire cpac_pkg::cpac_cmd_t            cmd,
    input  wire logic [cpac_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           m_tready,
    output      cpac_pkg::cpac_status_t         status,
    output      logic                           m_tvalid,
    output      logic [cpac_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                           m_tlast
);

    localparam int ADDR_W = $clog2(CHANNEL_COUNT);

    logic [cpac_pkg::CHAN_W-1:0]    chan_reg, chan_next;
    logic                           hit_reg, hit_next;
    logic [cpac_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [cpac_pkg::SHADE_W-1:0]   shade_reg, shade_next;
    logic                           end_reg, end_next;
    logic [cpac_pkg::SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic [CHANNEL_COUNT-1:0]       valid_reg, valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic [cpac_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    logic [ADDR_W-1:0]              ch_idx;
    logic                           in_range;
    logic                           is_last;
    logic [cpac_pkg::LEVEL_W-1:0]   ram_rdata;
    logic [cpac_pkg::LEVEL_W-1:0]   old_level;
    logic [cpac_pkg::SUM_W-1:0]     level_sum;
    logic [cpac_pkg::LEVEL_W-1:0]   new_level;

    assign ch_idx   = chan_reg[ADDR_W-1:0];
    assign in_range = chan_reg < cpac_pkg::CHAN_W'(CHANNEL_COUNT);
    assign is_last  = chan_reg == cpac_pkg::CHAN_W'(CHANNEL_COUNT - 1);

    // Per-channel level store; an entry not yet written reads as zero
    cpac_ram #(
        .WIDTH (cpac_pkg::LEVEL_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_level_ram (
        .aclk  (aclk),
        .we    (cmd.calc && in_range),
        .waddr (ch_idx),
        .wdata (new_level),
        .re    (cmd.read),
        .raddr (ch_idx),
        .rdata (ram_rdata)
    );

    // Exponential average: (3*old + 125*hit) / 4
    always_comb begin
        old_level = '0;
        if (in_range && valid_reg[ch_idx]) begin
            old_level = ram_rdata;
        end
        level_sum = cpac_pkg::SUM_W'(old_level) + cpac_pkg::SUM_W'({old_level, 1'b0})
                  + (hit_reg ? cpac_pkg::SUM_W'(125) : '0);
        new_level = level_sum[cpac_pkg::SUM_W-1:2];
    end

    // Next values of the working and output registers
    always_comb begin
        chan_next      = chan_reg;
        hit_next       = hit_reg;
        level_next     = level_reg;
        shade_next     = shade_reg;
        end_next       = end_reg;
        sweep_next     = sweep_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.accept) begin
            chan_next = s_tdata[cpac_pkg::CHAN_W-1:0];
            hit_next  = s_tdata[cpac_pkg::CHAN_W];
        end

        // An out-of-range channel leaves the level store, valid bits and sweep count alone and reports level zero
        if (cmd.calc) begin
            level_next = '0;
            shade_next = '0;
            end_next   = 1'b0;
            if (in_range) begin
                level_next         = new_level;
                shade_next         = cpac_pkg::SHADE_LUT[new_level];
                valid_next[ch_idx] = 1'b1;
                if (is_last) begin
                    end_next   = 1'b1;
                    sweep_next = sweep_reg + cpac_pkg::SWEEP_W'(1);
                end
            end
        end

        // Load the output beat, or drain it when taken
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {{cpac_pkg::M_PAD_W{1'b0}}, sweep_reg,
                              cpac_pkg::MAGMA_LUT[shade_reg], shade_reg, level_reg, chan_reg};
            out_last_next  = end_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sweep_reg     <= sweep_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        chan_reg     <= chan_next;
        hit_reg      <= hit_next;
        level_reg    <= level_next;
        shade_reg    <= shade_next;
        end_reg      <= end_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign status.out_busy = out_valid_reg;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tlast         = out_last_reg;

endmodule

`default_nettype wire
